// File: src/zsei_pkg.sv
// Package of the zoom stop exponential interpolator: types, codes and constants.
`timescale 1ns / 1ps
`default_nettype none

package zsei_pkg;

  // Sequencer states
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_DIV,
    ST_LIN,
    ST_LINF,
    ST_NORM,
    ST_SQ,
    ST_SQC,
    ST_DM,
    ST_DMF,
    ST_EXP,
    ST_EXPC,
    ST_PM,
    ST_PF,
    ST_OUT
  } state_e;

  // Result kinds
  localparam logic [1:0] KIND_INTERP    = 2'd0;
  localparam logic [1:0] KIND_NO_DRAW   = 2'd1;
  localparam logic [1:0] KIND_NO_STOPS  = 2'd2;
  localparam logic [1:0] KIND_INVALID   = 2'd3;

  // Register indexes
  localparam logic [2:0] REG_STOP_COUNT  = 3'd0;
  localparam logic [2:0] REG_ZOOM_OFFSET = 3'd1;
  localparam logic [2:0] REG_STOP_BASE   = 3'd2;

  localparam logic [15:0] ZOOM_OFFSET_RESET = 16'd4096;
  localparam logic [31:0] VALUE_ONE         = 32'h0001_0000;
  localparam logic [31:0] VALUE_NO_DRAW     = 32'h8000_0000;
  localparam logic [30:0] Q30_ONE           = 31'h4000_0000;

  // Integer square root, bit by bit (elaboration only)
  function automatic logic [63:0] isqrt64(input logic [63:0] val);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = val;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // 2^(2^-k) in Q1.30, by k repeated square roots of 2.0
  function automatic logic [31:0] exp_root(input int k);
    logic [63:0] c;
    c = 64'h8000_0000;
    for (int j = 1; j <= 32; j++) begin
      if (j <= k) c = isqrt64(c << 30);
    end
    return c[31:0];
  endfunction

endpackage

`default_nettype wire

// File: src/zsei_mul.sv
// Shared unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none

module zsei_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  wire logic             clk_i,
  input  wire logic [AW-1:0]    a_i,
  input  wire logic [BW-1:0]    b_i,
  output logic      [AW+BW-1:0] p_o
);

  logic [AW+BW-1:0] p_q;

  // One product a cycle, ready the cycle after the operands
  always_ff @(posedge clk_i) begin
    p_q <= (AW+BW)'(a_i) * (AW+BW)'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

// File: src/zoom_stop_exponential_interpolator_unit.sv
// Top level of the zoom stop exponential interpolator.
//
// Usage: write stop_count (index 0), zoom_offset (1) and the stops (2..7)
// on the cfg channel while idle; cfg_ready_o is always high. Each zoom beat
// on s_axis gives one result beat on m_axis: value Q16.16 on tdata, kind on tuser.
// The zoom is offset and saturated, the stops are scanned one per cycle,
// the zoom fraction comes from a 32-step restoring divider, and the
// exponential path runs log2 (normalise plus EXP_ITERATIONS squarings),
// a scaling product, exp2 (up to EXP_ITERATIONS root products) and a final
// product, all on one shared multiplier.
// One item at a time: s_axis_tready_o is high only while the sequencer idles.
// The result sits in an output register, so a new zoom is taken while it
// waits; a stalled receiver holds the next finished result in the sequencer.
// Reset clears the configuration registers to their defaults (offset 4096, no stops).
`timescale 1ns / 1ps
`default_nettype none

module zoom_stop_exponential_interpolator_unit #(
  parameter int MAX_STOPS      = 6,
  parameter int EXP_ITERATIONS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // zoom input: [15:0] zoom_level
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,
  // result: [31:0] result_value
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic      [31:0] m_axis_tdata_o,
  // result kind: [1:0] result_kind
  output logic      [1:0]  m_axis_tuser_o,
  // configuration write
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [63:0] cfg_data_i
);

  localparam int F  = EXP_ITERATIONS;
  localparam int LW = F + 5;
  localparam int EW = LW + 2;
  localparam int MW = (LW > 32) ? LW : 32;
  localparam int PW = MW + 32;
  localparam int IW = $clog2(F);
  localparam int SW = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
  localparam logic [IW-1:0] ITER_LAST = IW'(F - 1);
  localparam logic [2:0]    MAX_CNT   = 3'(MAX_STOPS);

  // Configuration registers
  logic [2:0]  cnt_q;
  logic [15:0] zoff_q;
  logic [15:0] sz_q [MAX_STOPS];
  logic [31:0] sv_q [MAX_STOPS];

  // Sequencer and datapath
  zsei_pkg::state_e state_q, state_d;
  logic [15:0] z_q, z_d;
  logic [2:0]  idx_q, idx_d;
  logic        lo_q, lo_d, hi_q, hi_d;
  logic [15:0] zl_q, zl_d, zu_q, zu_d;
  logic signed [31:0] vl_q, vl_d, vu_q, vu_d;
  logic [31:0] dq_q, dq_d;
  logic [15:0] rem_q, rem_d;
  logic [4:0]  dcnt_q, dcnt_d;
  logic [31:0] nv_q, nv_d;
  logic [4:0]  k_q, k_d;
  logic [30:0] x_q, x_d;
  logic [F-1:0] frac_q, frac_d;
  logic [LW-1:0] lb_q, lb_d;
  logic        side_q, side_d;
  logic        dneg_q, dneg_d;
  logic [IW-1:0] it_q, it_d;
  logic [F-1:0] r_q, r_d;
  logic signed [6:0] n_q, n_d;
  logic [30:0] m_q, m_d;
  logic [31:0] res_val_q, res_val_d;
  logic [1:0]  res_kind_q, res_kind_d;
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_val_q, out_val_d;
  logic [1:0]  out_kind_q, out_kind_d;

  // Helper signals
  logic [2:0]  cnt_eff;
  logic [16:0] zsum;
  logic [15:0] scan_sz;
  logic [31:0] scan_sv;
  logic [31:0] abs_vl, abs_vu;
  logic [15:0] den;
  logic [16:0] div_t;
  logic        div_ge;
  logic [16:0] f;
  logic signed [LW:0] d_s;
  logic [LW-1:0] d_abs;
  logic [MW-1:0] mul_a;
  logic [31:0]   mul_b;
  logic [PW-1:0] prod;
  logic [30:0] root_tab [F];
  logic [30:0] root_sel;
  logic        rbit;
  logic [32:0] x2;
  logic [F-1:0] frac_new;
  logic [PW-1:0] e_mq, e_sh;
  logic [EW-1:0] e_u, e_s;
  logic [31:0] lin_q;
  logic signed [7:0] s_sh;
  logic [7:0]  ns_sh;
  logic [63:0] p_fin, lim, pp;
  logic [31:0] pf_val;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == zsei_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_val_q;
  assign m_axis_tuser_o  = out_kind_q;

  assign cnt_eff = (cnt_q > MAX_CNT) ? MAX_CNT : cnt_q;
  assign zsum    = {1'b0, s_axis_tdata_i} + {1'b0, zoff_q};
  assign scan_sz = sz_q[idx_q[SW-1:0]];
  assign scan_sv = sv_q[idx_q[SW-1:0]];
  assign abs_vl  = vl_q[31] ? 32'(-vl_q) : 32'(vl_q);
  assign abs_vu  = vu_q[31] ? 32'(-vu_q) : 32'(vu_q);

  // Restoring divider step
  assign den    = zu_q - zl_q;
  assign div_t  = {rem_q, dq_q[31]};
  assign div_ge = (div_t >= {1'b0, den});
  assign f      = dq_q[16:0];

  // Log difference
  assign d_s   = $signed({1'b0, lb_q}) - $signed({1'b0, k_q, frac_q});
  assign d_abs = d_s[LW] ? LW'(-d_s) : d_s[LW-1:0];

  // Root constants 2^(2^-k), k = 1..F
  for (genvar g = 0; g < F; g++) begin : g_root
    assign root_tab[g] = 31'(zsei_pkg::exp_root(g + 1));
  end
  assign root_sel = root_tab[it_q];
  assign rbit     = r_q[ITER_LAST - it_q];

  // Squaring result
  assign x2       = prod[62:30];
  assign frac_new = {frac_q[F-2:0], x2[31]};

  // Scaled exponent, floored
  always_comb begin
    e_mq = dneg_q ? (prod + PW'(65535)) : prod;
    e_sh = e_mq >> 16;
    e_u  = e_sh[EW-1:0];
    e_s  = dneg_q ? EW'(-e_u) : e_u;
  end

  // Linear interpolation magnitude
  assign lin_q = prod[47:16];

  // Final scaling and saturation
  always_comb begin
    p_fin = prod[63:0];
    lim   = vl_q[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
    s_sh  = $signed({n_q[6], n_q}) - 8'sd30;
    ns_sh = 8'(-s_sh);
    pp    = p_fin;
    if (!s_sh[7] && (s_sh != 8'sd0)) begin
      if ((s_sh >= 8'sd40) || (p_fin > (lim >> s_sh[5:0]))) pp = lim;
      else pp = p_fin << s_sh[5:0];
    end else if (s_sh[7]) begin
      pp = p_fin >> ns_sh;
    end
    if (pp > lim) pp = lim;
    pf_val = vl_q[31] ? 32'(-pp) : pp[31:0];
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      zsei_pkg::ST_LIN: begin
        mul_a = MW'(f);
        mul_b = abs_vu;
      end
      zsei_pkg::ST_SQ: begin
        mul_a = MW'(x_q);
        mul_b = {1'b0, x_q};
      end
      zsei_pkg::ST_DM: begin
        mul_a = MW'(d_abs);
        mul_b = 32'(f);
      end
      zsei_pkg::ST_EXP: begin
        mul_a = MW'(m_q);
        mul_b = {1'b0, root_sel};
      end
      zsei_pkg::ST_PM: begin
        mul_a = MW'(abs_vl);
        mul_b = {1'b0, m_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  zsei_mul #(.AW(MW), .BW(32)) u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Next state and datapath
  always_comb begin
    state_d    = state_q;
    z_d        = z_q;
    idx_d      = idx_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    zl_d       = zl_q;
    zu_d       = zu_q;
    vl_d       = vl_q;
    vu_d       = vu_q;
    dq_d       = dq_q;
    rem_d      = rem_q;
    dcnt_d     = dcnt_q;
    nv_d       = nv_q;
    k_d        = k_q;
    x_d        = x_q;
    frac_d     = frac_q;
    lb_d       = lb_q;
    side_d     = side_q;
    dneg_d     = dneg_q;
    it_d       = it_q;
    r_d        = r_q;
    n_d        = n_q;
    m_d        = m_q;
    res_val_d  = res_val_q;
    res_kind_d = res_kind_q;
    out_valid_d = out_valid_q;
    out_val_d  = out_val_q;
    out_kind_d = out_kind_q;

    if (out_valid_q && m_axis_tready_i) out_valid_d = 1'b0;

    unique case (state_q)
      zsei_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          z_d     = zsum[16] ? 16'hFFFF : zsum[15:0];
          lo_d    = 1'b0;
          hi_d    = 1'b0;
          idx_d   = '0;
          state_d = (cnt_eff != 3'd0) ? zsei_pkg::ST_SCAN : zsei_pkg::ST_DECIDE;
        end
      end
      // One stop a cycle; earlier stop wins ties
      zsei_pkg::ST_SCAN: begin
        if ((scan_sz <= z_q) && (!lo_q || (zl_q < scan_sz))) begin
          lo_d = 1'b1;
          zl_d = scan_sz;
          vl_d = scan_sv;
        end
        if ((scan_sz >= z_q) && (!hi_q || (zu_q > scan_sz))) begin
          hi_d = 1'b1;
          zu_d = scan_sz;
          vu_d = scan_sv;
        end
        idx_d = idx_q + 3'd1;
        if (idx_q == cnt_eff - 3'd1) state_d = zsei_pkg::ST_DECIDE;
      end
      zsei_pkg::ST_DECIDE: begin
        if (lo_q && hi_q) begin
          if ((zl_q == zu_q) || (vl_q == vu_q)) begin
            res_val_d  = vl_q;
            res_kind_d = zsei_pkg::KIND_INTERP;
            state_d    = zsei_pkg::ST_OUT;
          end else if ((vl_q != 32'sd0) && ((vu_q == 32'sd0) || (vl_q[31] != vu_q[31])))
          begin
            res_val_d  = '0;
            res_kind_d = zsei_pkg::KIND_INVALID;
            state_d    = zsei_pkg::ST_OUT;
          end else begin
            dq_d    = {z_q - zl_q, 16'h0000};
            rem_d   = '0;
            dcnt_d  = '0;
            state_d = zsei_pkg::ST_DIV;
          end
        end else if (lo_q || hi_q) begin
          res_val_d  = zsei_pkg::VALUE_NO_DRAW;
          res_kind_d = zsei_pkg::KIND_NO_DRAW;
          state_d    = zsei_pkg::ST_OUT;
        end else begin
          res_val_d  = zsei_pkg::VALUE_ONE;
          res_kind_d = zsei_pkg::KIND_NO_STOPS;
          state_d    = zsei_pkg::ST_OUT;
        end
      end
      // Zoom fraction, one quotient bit a cycle
      zsei_pkg::ST_DIV: begin
        rem_d  = div_ge ? 16'(div_t - {1'b0, den}) : div_t[15:0];
        dq_d   = {dq_q[30:0], div_ge};
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) begin
          if (vl_q == 32'sd0) begin
            state_d = zsei_pkg::ST_LIN;
          end else begin
            nv_d    = abs_vu;
            k_d     = 5'd31;
            side_d  = 1'b0;
            state_d = zsei_pkg::ST_NORM;
          end
        end
      end
      zsei_pkg::ST_LIN: state_d = zsei_pkg::ST_LINF;
      zsei_pkg::ST_LINF: begin
        res_val_d  = vu_q[31] ? 32'(-lin_q) : lin_q;
        res_kind_d = zsei_pkg::KIND_INTERP;
        state_d    = zsei_pkg::ST_OUT;
      end
      // Normalise magnitude to top bit set, tracking the exponent
      zsei_pkg::ST_NORM: begin
        if (nv_q[31]) begin
          x_d     = nv_q[31:1];
          it_d    = '0;
          frac_d  = '0;
          state_d = zsei_pkg::ST_SQ;
        end else begin
          nv_d = nv_q << 1;
          k_d  = k_q - 5'd1;
        end
      end
      zsei_pkg::ST_SQ: state_d = zsei_pkg::ST_SQC;
      // One log2 fraction bit per squaring
      zsei_pkg::ST_SQC: begin
        x_d    = x2[31] ? x2[31:1] : x2[30:0];
        frac_d = frac_new;
        if (it_q == ITER_LAST) begin
          if (!side_q) begin
            lb_d    = {k_q, frac_new};
            side_d  = 1'b1;
            nv_d    = abs_vl;
            k_d     = 5'd31;
            state_d = zsei_pkg::ST_NORM;
          end else begin
            state_d = zsei_pkg::ST_DM;
          end
        end else begin
          it_d    = it_q + 1'b1;
          state_d = zsei_pkg::ST_SQ;
        end
      end
      zsei_pkg::ST_DM: begin
        dneg_d  = d_s[LW];
        state_d = zsei_pkg::ST_DMF;
      end
      zsei_pkg::ST_DMF: begin
        r_d     = e_s[F-1:0];
        n_d     = e_s[EW-1:F];
        m_d     = zsei_pkg::Q30_ONE;
        it_d    = '0;
        state_d = zsei_pkg::ST_EXP;
      end
      // exp2 fraction: multiply in a root for each set bit
      zsei_pkg::ST_EXP: begin
        if (rbit) begin
          state_d = zsei_pkg::ST_EXPC;
        end else if (it_q == ITER_LAST) begin
          state_d = zsei_pkg::ST_PM;
        end else begin
          it_d = it_q + 1'b1;
        end
      end
      zsei_pkg::ST_EXPC: begin
        m_d = prod[60:30];
        if (it_q == ITER_LAST) begin
          state_d = zsei_pkg::ST_PM;
        end else begin
          it_d    = it_q + 1'b1;
          state_d = zsei_pkg::ST_EXP;
        end
      end
      zsei_pkg::ST_PM: state_d = zsei_pkg::ST_PF;
      zsei_pkg::ST_PF: begin
        res_val_d  = pf_val;
        res_kind_d = zsei_pkg::KIND_INTERP;
        state_d    = zsei_pkg::ST_OUT;
      end
      // Hand over to the output register once it is free
      zsei_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          out_val_d   = res_val_q;
          out_kind_d  = res_kind_q;
          state_d     = zsei_pkg::ST_IDLE;
        end
      end
      default: state_d = zsei_pkg::ST_IDLE;
    endcase
  end

  // Control state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= zsei_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
      zoff_q      <= zsei_pkg::ZOOM_OFFSET_RESET;
      for (int i = 0; i < MAX_STOPS; i++) begin
        sz_q[i] <= '0;
        sv_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        if (cfg_index_i == zsei_pkg::REG_STOP_COUNT) cnt_q <= cfg_data_i[2:0];
        if (cfg_index_i == zsei_pkg::REG_ZOOM_OFFSET) zoff_q <= cfg_data_i[15:0];
        for (int i = 0; i < MAX_STOPS; i++) begin
          if (cfg_index_i == zsei_pkg::REG_STOP_BASE + 3'(i)) begin
            sz_q[i] <= cfg_data_i[15:0];
            sv_q[i] <= cfg_data_i[63:32];
          end
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    z_q        <= z_d;
    idx_q      <= idx_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    zl_q       <= zl_d;
    zu_q       <= zu_d;
    vl_q       <= vl_d;
    vu_q       <= vu_d;
    dq_q       <= dq_d;
    rem_q      <= rem_d;
    dcnt_q     <= dcnt_d;
    nv_q       <= nv_d;
    k_q        <= k_d;
    x_q        <= x_d;
    frac_q     <= frac_d;
    lb_q       <= lb_d;
    side_q     <= side_d;
    dneg_q     <= dneg_d;
    it_q       <= it_d;
    r_q        <= r_d;
    n_q        <= n_d;
    m_q        <= m_d;
    res_val_q  <= res_val_d;
    res_kind_q <= res_kind_d;
    out_val_q  <= out_val_d;
    out_kind_q <= out_kind_d;
  end

endmodule

`default_nettype wire

// File: src/zsei_checker.sv
// Port-level assertions for the interpolator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module zsei_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [31:0] m_axis_tdata_o,
  input wire logic [1:0]  m_axis_tuser_o
);

  // Busy right after taking a zoom beat
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted while busy");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i)
      |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)))
    else $error("result beat dropped or changed under stall");

  // Fixed values of the special kinds
  a_no_draw: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == zsei_pkg::KIND_NO_DRAW))
      |-> (m_axis_tdata_o == zsei_pkg::VALUE_NO_DRAW))
    else $error("no_draw result with wrong value");

  a_no_stops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == zsei_pkg::KIND_NO_STOPS))
      |-> (m_axis_tdata_o == zsei_pkg::VALUE_ONE))
    else $error("no-stops result with wrong value");

  a_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == zsei_pkg::KIND_INVALID))
      |-> (m_axis_tdata_o == 32'h0))
    else $error("invalid result with nonzero value");

endmodule

bind zoom_stop_exponential_interpolator_unit zsei_checker u_zsei_checker (.*);

`default_nettype wire
